@@ rtl/crossfader_gain_frame_defines.svh @@
// Assertion helpers used by crossfader_gain_frame.sv.
`ifndef CROSSFADER_GAIN_FRAME_DEFINES_SVH
`define CROSSFADER_GAIN_FRAME_DEFINES_SVH

// same-cycle implication
`define CGF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define CGF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/cgf_pkg.sv @@
`timescale 1ns / 1ps
package cgf_pkg;

  localparam logic [15:0] ONE_Q15     = 16'd32768;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam logic [2:0] MODE_STANDARD = 3'd0;
  localparam logic [2:0] MODE_SCENE    = 3'd1;
  localparam logic [2:0] MODE_LAYER_B  = 3'd2;
  localparam logic [2:0] MODE_LAYER_A  = 3'd3;
  localparam logic [2:0] MODE_PAIR     = 3'd4;

  localparam logic [2:0] CURVE_FULL   = 3'd0;
  localparam logic [2:0] CURVE_LINEAR = 3'd1;
  localparam logic [2:0] CURVE_SMOOTH = 3'd2;
  localparam logic [2:0] CURVE_SINE   = 3'd3;
  localparam logic [2:0] CURVE_FAST   = 3'd4;

  localparam logic [1:0] FLOOR_KILL = 2'd0;
  localparam logic [1:0] FLOOR_M24  = 2'd1;
  localparam logic [1:0] FLOOR_M18  = 2'd2;
  localparam logic [1:0] FLOOR_M14  = 2'd3;

  localparam logic [1:0] SLOT_UNITY = 2'd0;
  localparam logic [1:0] SLOT_A     = 2'd1;
  localparam logic [1:0] SLOT_B     = 2'd2;

  localparam logic [2:0] REG_FADE_MODE    = 3'd0;
  localparam logic [2:0] REG_CURVE_SELECT = 3'd1;
  localparam logic [2:0] REG_FLOOR_SELECT = 3'd2;
  localparam logic [2:0] REG_SWAP_SIDES   = 3'd3;
  localparam logic [2:0] REG_FLIP_TRAVEL  = 3'd4;
  localparam logic [2:0] REG_SLOT_ASSIGN  = 3'd5;
  localparam logic [2:0] REG_LEFT_LEVELS  = 3'd6;
  localparam logic [2:0] REG_RIGHT_LEVELS = 3'd7;

  // reciprocals: floor(n / d) == (n * M) >> S over the operand ranges used
  localparam logic [23:0] RECIP_63 = 24'd8521761;
  localparam int          SHIFT_63 = 29;
  localparam logic [21:0] RECIP_9  = 22'd3728271;
  localparam int          SHIFT_9  = 25;
  localparam logic [21:0] RECIP_18 = 22'd3728271;
  localparam int          SHIFT_18 = 26;

  function automatic logic [15:0] floor_gain(input logic [1:0] sel);
    logic [15:0] g;
    case (sel)
      FLOOR_KILL: g = 16'd0;
      FLOOR_M24:  g = 16'd2068;
      FLOOR_M18:  g = 16'd4125;
      FLOOR_M14:  g = 16'd6538;
      default:    g = 16'd0;
    endcase
    return g;
  endfunction

  // sine of a Q30 angle by Taylor series, rounded to Q15
  function automatic logic [15:0] rom_entry(input logic [63:0] x);
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] r;
    sum  = x;
    term = x;
    for (int n = 1; n <= 7; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if ((n % 2) == 1) sum = sum - term;
      else sum = sum + term;
    end
    r = (sum + 64'd16384) >> 15;
    if (r > 64'(ONE_Q15)) r = 64'(ONE_Q15);
    return r[15:0];
  endfunction

endpackage

@@ rtl/cgf_sine_interp.sv @@
`timescale 1ns / 1ps
module cgf_sine_interp import cgf_pkg::*; #(
  parameter int SINE_TABLE_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] x,
  output logic [15:0] y
);

  localparam int N  = SINE_TABLE_ENTRIES;
  localparam int IW = $clog2(N + 1);
  localparam int SW = 16 + IW;

  logic [15:0] rom [0:N];

  for (genvar k = 0; k <= N; k++) begin : g_rom
    localparam logic [63:0] ANGLE = 64'(k) * HALF_PI_Q30 / 64'(N);
    assign rom[k] = rom_entry(ANGLE);
  end

  logic [SW-1:0]    scaled;
  logic [SW-16:0]   idx;
  logic             at_end;
  logic [IW-1:0]    idx_lo;
  logic [IW-1:0]    idx_hi;
  logic [15:0]      lo;
  logic [15:0]      hi;
  logic [14:0]      frac;
  logic             up;
  logic [15:0]      diff;
  logic [31:0]      prod;
  logic [15:0]      step;

  always_comb begin
    scaled = SW'(x) * SW'(N);
    idx    = scaled[SW-1:15];
    at_end = (idx >= (SW-15)'(N));
    idx_lo = at_end ? IW'(N) : idx[IW-1:0];
    idx_hi = at_end ? IW'(N) : idx[IW-1:0] + IW'(1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo   <= rom[idx_lo];
      hi   <= rom[idx_hi];
      frac <= at_end ? 15'd0 : scaled[14:0];
    end
  end

  always_comb begin
    up   = (hi >= lo);
    diff = up ? hi - lo : lo - hi;
    prod = 32'(diff) * 32'(frac) + 32'd16384;
    step = prod[30:15];
  end

  always_ff @(posedge clk) begin
    if (en) y <= up ? lo + step : lo - step;
  end

endmodule

@@ rtl/crossfader_gain_frame.sv @@
`timescale 1ns / 1ps
// Crossfader gain frame: one crossfader position in, four slot gains out.
// Input channel: position (Q1.15, values above 32768 clamp) with in_valid and
// in_stall. Output channel: gain_slot0..gain_slot3 with out_valid and
// out_stall; slots at or above NUM_TARGETS read 0.
// Configuration: cfg_we writes cfg_data to register cfg_index.
// Write only while no beat is in flight.
// Throughput is one beat per cycle while the pipeline is not stalled, set by
// a seven-stage pipeline ending in the output register, with the sine table
// read in stage 2 and the cubic smoothing products spread over stages 2 to 4.
// While out_valid is high and out_stall is asserted, every stage holds and
// in_stall rises; nothing is dropped or repeated.
// Reset (rst, synchronous) empties the pipeline and restores the registers:
// standard mode, linear curve, no floor, no swap, no flip, all slots unity,
// scene levels zero.
module crossfader_gain_frame import cgf_pkg::*; #(
  parameter int NUM_TARGETS        = 4,
  parameter int SINE_TABLE_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] position,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] gain_slot0,
  output logic [15:0] gain_slot1,
  output logic [15:0] gain_slot2,
  output logic [15:0] gain_slot3
);

`include "crossfader_gain_frame_defines.svh"

  logic [2:0]  fade_mode;
  logic [2:0]  curve_select;
  logic [1:0]  floor_select;
  logic        swap_sides;
  logic        flip_travel;
  logic [7:0]  slot_assign;
  logic [63:0] slot_left_levels;
  logic [63:0] slot_right_levels;

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_mode         <= MODE_STANDARD;
      curve_select      <= CURVE_LINEAR;
      floor_select      <= FLOOR_KILL;
      swap_sides        <= 1'b0;
      flip_travel       <= 1'b0;
      slot_assign       <= 8'd0;
      slot_left_levels  <= 64'd0;
      slot_right_levels <= 64'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FADE_MODE:    fade_mode         <= cfg_data[2:0];
        REG_CURVE_SELECT: curve_select      <= cfg_data[2:0];
        REG_FLOOR_SELECT: floor_select      <= cfg_data[1:0];
        REG_SWAP_SIDES:   swap_sides        <= cfg_data[0];
        REG_FLIP_TRAVEL:  flip_travel       <= cfg_data[0];
        REG_SLOT_ASSIGN:  slot_assign       <= cfg_data[7:0];
        REG_LEFT_LEVELS:  slot_left_levels  <= cfg_data;
        REG_RIGHT_LEVELS: slot_right_levels <= cfg_data;
        default: ;
      endcase
    end
  end

  logic       en;
  logic [7:1] vld;

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[7];

  always_ff @(posedge clk) begin
    if (rst) vld <= 7'd0;
    else if (en) vld <= {vld[6:1], in_valid};
  end

  // stage 1: clamp and mirror
  logic [15:0] pc;
  logic [15:0] p1, pm1;

  assign pc = (position > ONE_Q15) ? ONE_Q15 : position;

  always_ff @(posedge clk) begin
    if (en) begin
      p1  <= flip_travel ? ONE_Q15 - pc : pc;
      pm1 <= flip_travel ? pc : ONE_Q15 - pc;
    end
  end

  // stage 2: squares, reciprocal divides
  logic [22:0] fc_na, fc_nb;
  logic [46:0] fc_pa, fc_pb;
  logic [20:0] fs_na, fs_nb;
  logic [42:0] fs_pa, fs_pb;
  logic [21:0] u_n100;
  logic [20:0] u_num;
  logic [42:0] u_prod;
  logic [31:0] pp_full;

  logic [30:0] pp2;
  logic [16:0] c2;
  logic [15:0] p2, pm2, fca2, fcb2, fsa2, fsb2, u2;

  always_comb begin
    fc_na   = 23'(pm1) * 23'd127 + 23'd31;
    fc_nb   = 23'(p1) * 23'd127 + 23'd31;
    fc_pa   = 47'(fc_na) * 47'(RECIP_63);
    fc_pb   = 47'(fc_nb) * 47'(RECIP_63);
    fs_na   = 21'(pm1) * 21'd50 + 21'd4;
    fs_nb   = 21'(p1) * 21'd50 + 21'd4;
    fs_pa   = 43'(fs_na) * 43'(RECIP_9);
    fs_pb   = 43'(fs_nb) * 43'(RECIP_9);
    u_n100  = 22'(p1) * 22'd100;
    u_num   = 21'(u_n100 - 22'd1343488 + 22'd9);
    u_prod  = 43'(u_num) * 43'(RECIP_18);
    pp_full = 32'(p1) * 32'(p1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2   <= p1;
      pm2  <= pm1;
      pp2  <= pp_full[30:0];
      c2   <= 17'd98304 - {p1, 1'b0};
      fca2 <= (23'(p1) * 23'd127 <= 23'd2097152) ? ONE_Q15 : fc_pa[SHIFT_63+15:SHIFT_63];
      fcb2 <= (23'(p1) * 23'd127 >= 23'd2064384) ? ONE_Q15 : fc_pb[SHIFT_63+15:SHIFT_63];
      fsa2 <= (fs_pa[42:SHIFT_9] > 18'(ONE_Q15)) ? ONE_Q15 : fs_pa[SHIFT_9+15:SHIFT_9];
      fsb2 <= (fs_pb[42:SHIFT_9] > 18'(ONE_Q15)) ? ONE_Q15 : fs_pb[SHIFT_9+15:SHIFT_9];
      if (u_n100 <= 22'd1343488) u2 <= 16'd0;
      else if (u_prod[42:SHIFT_18] > 17'(ONE_Q15)) u2 <= ONE_Q15;
      else u2 <= u_prod[SHIFT_18+15:SHIFT_18];
    end
  end

  logic [15:0] sin_a3, sin_b3;

  cgf_sine_interp #(.SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)) u_sine_a (
    .clk(clk), .en(en), .x(pm1), .y(sin_a3)
  );

  cgf_sine_interp #(.SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)) u_sine_b (
    .clk(clk), .en(en), .x(p1), .y(sin_b3)
  );

  // stage 3
  logic [31:0] uu_full;
  logic [47:0] v3;
  logic [30:0] uu3;
  logic [16:0] cu3;
  logic [15:0] p3, pm3, fca3, fcb3, fsa3, fsb3;

  assign uu_full = 32'(u2) * 32'(u2);

  always_ff @(posedge clk) begin
    if (en) begin
      v3   <= 48'(pp2) * 48'(c2);
      uu3  <= uu_full[30:0];
      cu3  <= 17'd98304 - {u2, 1'b0};
      p3   <= p2;
      pm3  <= pm2;
      fca3 <= fca2;
      fcb3 <= fcb2;
      fsa3 <= fsa2;
      fsb3 <= fsb2;
    end
  end

  // stage 4
  logic [47:0] s_round;
  logic [47:0] vu4;
  logic [31:0] ss4;
  logic [15:0] s4, p4, pm4, fca4, fcb4, fsa4, fsb4, sin_a4, sin_b4;

  assign s_round = v3 + 48'd536870912;

  always_ff @(posedge clk) begin
    if (en) begin
      s4     <= s_round[45:30];
      vu4    <= 48'(uu3) * 48'(cu3);
      ss4    <= 32'(sin_b3) * 32'(sin_b3);
      p4     <= p3;
      pm4    <= pm3;
      fca4   <= fca3;
      fcb4   <= fcb3;
      fsa4   <= fsa3;
      fsb4   <= fsb3;
      sin_a4 <= sin_a3;
      sin_b4 <= sin_b3;
    end
  end

  // stage 5: curve select
  logic [47:0] su_round;
  logic [31:0] sq_round;
  logic [15:0] a_raw, b_raw, q_raw;
  logic [15:0] a5, b5, q5;

  always_comb begin
    su_round = vu4 + 48'd536870912;
    sq_round = ss4 + 32'd16384;
    case (curve_select)
      CURVE_FULL:   begin a_raw = fca4;          b_raw = fcb4;   end
      CURVE_LINEAR: begin a_raw = pm4;           b_raw = p4;     end
      CURVE_SMOOTH: begin a_raw = ONE_Q15 - s4;  b_raw = s4;     end
      CURVE_SINE:   begin a_raw = sin_a4;        b_raw = sin_b4; end
      CURVE_FAST:   begin a_raw = fsa4;          b_raw = fsb4;   end
      default:      begin a_raw = ONE_Q15;       b_raw = ONE_Q15; end
    endcase
    case (curve_select)
      CURVE_SMOOTH: q_raw = s4;
      CURVE_SINE:   q_raw = sq_round[30:15];
      CURVE_FAST:   q_raw = su_round[45:30];
      default:      q_raw = p4;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a5 <= a_raw;
      b5 <= b_raw;
      q5 <= q_raw;
    end
  end

  // stage 6: mode override, floor, swap; scene products
  logic [15:0] a_m, b_m, a_f, b_f, fl;
  logic [15:0] a6, b6;

  always_comb begin
    a_m = a5;
    b_m = b5;
    case (fade_mode)
      MODE_LAYER_B: b_m = ONE_Q15;
      MODE_LAYER_A: begin a_m = ONE_Q15; b_m = a5; end
      MODE_PAIR:    b_m = a5;
      default: ;
    endcase
    fl  = floor_gain(floor_select);
    a_f = (a_m < fl) ? fl : a_m;
    b_f = (b_m < fl) ? fl : b_m;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a6 <= swap_sides ? b_f : a_f;
      b6 <= swap_sides ? a_f : b_f;
    end
  end

  logic [15:0] gain [4];

  for (genvar i = 0; i < 4; i++) begin : g_slot
    if (i < NUM_TARGETS) begin : g_on
      logic [15:0] lv, rv, l6, d;
      logic        up, up6;
      logic [30:0] prod6;
      logic [31:0] step;
      logic [1:0]  code;
      logic [15:0] side;

      always_comb begin
        lv = slot_left_levels[16*i +: 16];
        rv = slot_right_levels[16*i +: 16];
        if (lv > ONE_Q15) lv = ONE_Q15;
        if (rv > ONE_Q15) rv = ONE_Q15;
        up = (rv >= lv);
        d  = up ? rv - lv : lv - rv;
      end

      always_ff @(posedge clk) begin
        if (en) begin
          l6    <= lv;
          up6   <= up;
          prod6 <= 31'(32'(d) * 32'(q5));
        end
      end

      always_comb begin
        step = 32'(prod6) + 32'd16384;
        code = slot_assign[2*i +: 2];
        case (code)
          SLOT_UNITY: side = ONE_Q15;
          SLOT_A:     side = a6;
          SLOT_B:     side = b6;
          default:    side = 16'd0;
        endcase
      end

      always_ff @(posedge clk) begin
        if (en) begin
          if (fade_mode == MODE_SCENE)
            gain[i] <= up6 ? l6 + step[30:15] : l6 - step[30:15];
          else
            gain[i] <= side;
        end
      end
    end else begin : g_off
      assign gain[i] = 16'd0;
    end
  end

  assign gain_slot0 = gain[0];
  assign gain_slot1 = gain[1];
  assign gain_slot2 = gain[2];
  assign gain_slot3 = gain[3];

  `CGF_ASSERT_NEXT(a_hold, !en, $stable(vld))
  `CGF_ASSERT_NEXT(a_enter, en && in_valid, vld[1])
  `CGF_ASSERT_NOW(a_range, out_valid, gain_slot0 <= ONE_Q15 && gain_slot1 <= ONE_Q15 &&
    gain_slot2 <= ONE_Q15 && gain_slot3 <= ONE_Q15)
  `CGF_ASSERT_NOW(a_unused, out_valid && NUM_TARGETS < 4, gain_slot3 == 16'd0)

endmodule
